// ===== rtl/core/bta_pkg.sv =====
// Shared types and codes for the boundary-tag heap allocator.
// No dependencies.
package bta_pkg;

  localparam int DEF_PROCESSES    = 4;
  localparam int DEF_REGION_WORDS = 2048;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_STATS = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_NULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  proc;
    logic [14:0] want;
    logic [10:0] word;
    logic        quick;
    logic [1:0]  quick_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] payload_word;
    logic [13:0] alloc_bytes;
    logic [13:0] avail_bytes;
    logic [13:0] heap_bytes;
  } res_t;

endpackage

// ===== rtl/core/boundary_tag_heap_allocator.sv =====
// Boundary-tag first-fit heap allocator, one region per process. Once the
// sequencer takes an item off the command queue and dispatches it, a walk
// reads and then evaluates each block header it visits; neighbor reads, tag
// writes and result hand-off follow. All tag reads and writes share one
// memory port. Init rewrites the outer tags of every region, and the same
// sweep runs after reset before the first item is served. Zero-size allocate
// and null free are answered without a walk. Each queue registers a transfer
// before it takes effect on the other side.
module boundary_tag_heap_allocator
  import bta_pkg::*;
#(
  parameter int PROCESSES    = DEF_PROCESSES,
  parameter int REGION_WORDS = DEF_REGION_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [1:0]  process,
  input  logic [15:0] request_bytes,
  input  logic [10:0] block_word,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [10:0] payload_word,
  output logic [13:0] alloc_bytes,
  output logic [13:0] avail_bytes,
  output logic [13:0] heap_bytes
);
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_out;
  logic res_full;
  logic res_push;

  bta_front #(.PROCESSES(PROCESSES)) u_front (
    .opcode        (opcode),
    .process       (process),
    .request_bytes (request_bytes),
    .block_word    (block_word),
    .cmd           (cmd_in)
  );

  bta_fifo #(.W($bits(cmd_t))) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  bta_engine #(.PROCESSES(PROCESSES), .REGION_WORDS(REGION_WORDS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_room  (!res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  bta_fifo #(.W($bits(res_t))) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign status       = res_out.status;
  assign payload_word = res_out.payload_word;
  assign alloc_bytes  = res_out.alloc_bytes;
  assign avail_bytes  = res_out.avail_bytes;
  assign heap_bytes   = res_out.heap_bytes;

endmodule

// ===== rtl/core/bta_fifo.sv =====
// Two-entry queue carrying a packed word between front and back.
// Depends on nothing.
module bta_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/bta_front.sv =====
// Front end: folds the process number into range, rounds bytes to words
// and settles the requests that fail without a walk. Uses bta_pkg.
module bta_front
  import bta_pkg::*;
#(
  parameter int PROCESSES = DEF_PROCESSES
) (
  input  logic [1:0]  opcode,
  input  logic [1:0]  process,
  input  logic [15:0] request_bytes,
  input  logic [10:0] block_word,
  output cmd_t        cmd
);
  logic [2:0]  p;
  logic [16:0] rounded;

  always_comb begin
    p = {1'b0, process};
    for (int k = 0; k < 3; k++) begin
      if (int'(p) >= PROCESSES) p = p - 3'(PROCESSES);
    end
    rounded = {1'b0, request_bytes} + 17'd3;

    cmd.op           = opcode;
    cmd.proc         = p[1:0];
    cmd.want         = rounded[16:2];
    cmd.word         = block_word;
    cmd.quick        = 1'b0;
    cmd.quick_status = ST_OK;
    if (opcode == OP_ALLOC && rounded[16:2] == 15'd0) begin
      cmd.quick        = 1'b1;
      cmd.quick_status = ST_NOFIT;
    end else if (opcode == OP_FREE && block_word == 11'd0) begin
      cmd.quick        = 1'b1;
      cmd.quick_status = ST_NULL;
    end
  end

endmodule

// ===== rtl/core/bta_engine.sv =====
// Back end: tag memory and the sequencer that walks block chains for
// allocate, free and statistics, and rebuilds regions on init. Uses bta_pkg.
module bta_engine
  import bta_pkg::*;
#(
  parameter int PROCESSES    = DEF_PROCESSES,
  parameter int REGION_WORDS = DEF_REGION_WORDS
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_pop,
  input  logic res_room,
  output logic res_push,
  output res_t res
);
  localparam int DEPTH = PROCESSES * REGION_WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(REGION_WORDS) + 1;
  localparam int XW    = ($clog2(REGION_WORDS) + 2 > 16) ? $clog2(REGION_WORDS) + 2 : 16;
  localparam int PW    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam logic [XW-1:0] RW = XW'(REGION_WORDS);
  localparam logic [13:0] HEAP = 14'((REGION_WORDS * 4) % 16384);
  localparam logic [TW-1:0] INIT_TAG = TW'(0 - (REGION_WORDS - 2));

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_EV     = 4'd3;
  localparam logic [3:0] S_PRV_RD = 4'd4;
  localparam logic [3:0] S_PRV_EV = 4'd5;
  localparam logic [3:0] S_NXT_RD = 4'd6;
  localparam logic [3:0] S_NXT_EV = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [TW-1:0] mem [DEPTH];
  logic [TW-1:0] rdata;
  logic [AW-1:0] addr;
  logic          we;
  logic [TW-1:0] wdata;

  logic [3:0]    state;
  logic [1:0]    op;
  logic [AW-1:0] base;
  logic [XW-1:0] want;
  logic [XW-1:0] hdr;
  logic [XW-1:0] i;
  logic [XW-1:0] tsz;
  logic          split;
  logic [XW-1:0] lo;
  logic [XW-1:0] hi;
  logic [XW-1:0] total;
  logic [XW-1:0] acc_u;
  logic [XW-1:0] acc_f;
  logic [1:0]    wcnt;
  logic [1:0]    status;
  logic [XW-1:0] payload;
  logic [AW-1:0] init_addr;
  logic [PW-1:0] init_cnt;
  logic          init_ph;
  logic          init_reply;

  logic          neg;
  logic [TW-1:0] mag;
  logic [XW-1:0] sz;
  logic [XW-1:0] nxt;
  logic [XW-1:0] woff;
  logic [XW-1:0] rest;
  logic          wlast;
  logic [1:0]    fail_status;
  logic [XW+1:0] used_b;
  logic [XW+1:0] free_b;

  assign neg  = rdata[TW-1];
  assign mag  = neg ? (~rdata + TW'(1)) : rdata;
  assign sz   = XW'(mag);
  assign nxt  = i + sz + XW'(2);
  assign rest = tsz - want - XW'(2);
  assign fail_status = (op == OP_ALLOC) ? ST_NOFIT : ((op == OP_FREE) ? ST_NULL : ST_OK);

  // Tag writes: alloc updates two or four tags, free writes the merged pair
  always_comb begin
    woff  = lo;
    wdata = TW'(0) - TW'(total);
    wlast = (wcnt == 2'd1);
    if (op == OP_ALLOC) begin
      wlast = split ? (wcnt == 2'd3) : (wcnt == 2'd1);
      case (wcnt)
        2'd0: begin
          woff  = i;
          wdata = split ? TW'(want) : TW'(tsz);
        end
        2'd1: begin
          woff  = split ? (i + want + XW'(1)) : (i + tsz + XW'(1));
          wdata = split ? TW'(want) : TW'(tsz);
        end
        2'd2: begin
          woff  = i + want + XW'(2);
          wdata = TW'(0) - TW'(rest);
        end
        default: begin
          woff  = i + tsz + XW'(1);
          wdata = TW'(0) - TW'(rest);
        end
      endcase
    end else if (wcnt != 2'd0) begin
      woff = hi;
    end
  end

  always_comb begin
    we   = 1'b0;
    addr = base + AW'(i);
    case (state)
      S_INIT: begin
        we   = 1'b1;
        addr = init_addr;
      end
      S_PRV_RD: addr = base + AW'(hdr - XW'(1));
      S_NXT_RD: addr = base + AW'(hi + XW'(1));
      S_WR: begin
        we   = 1'b1;
        addr = base + AW'(woff);
      end
      default: addr = base + AW'(i);
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= (state == S_INIT) ? INIT_TAG : wdata;
    end
    rdata <= mem[addr];
  end

  assign cmd_pop  = (state == S_IDLE) && cmd_valid && res_room && !rst;
  assign res_push = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_addr  <= '0;
      init_cnt   <= '0;
      init_ph    <= 1'b0;
      init_reply <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            op      <= cmd.op;
            base    <= AW'(int'(cmd.proc) * REGION_WORDS);
            want    <= XW'(cmd.want);
            hdr     <= XW'(cmd.word) - XW'(1);
            i       <= '0;
            acc_u   <= '0;
            acc_f   <= '0;
            payload <= '0;
            status  <= cmd.quick ? cmd.quick_status : ST_OK;
            if (cmd.quick) begin
              state  <= S_DONE;
            end else if (cmd.op == OP_INIT) begin
              init_addr  <= '0;
              init_cnt   <= '0;
              init_ph    <= 1'b0;
              init_reply <= 1'b1;
              state      <= S_INIT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_INIT: begin
          if (!init_ph) begin
            init_addr <= init_addr + AW'(REGION_WORDS - 1);
            init_ph   <= 1'b1;
          end else if (int'(init_cnt) == PROCESSES - 1) begin
            state <= init_reply ? S_DONE : S_IDLE;
          end else begin
            init_addr <= init_addr + AW'(1);
            init_cnt  <= init_cnt + PW'(1);
            init_ph   <= 1'b0;
          end
        end
        S_RD: begin
          if (i >= RW) begin
            status <= fail_status;
            state  <= S_DONE;
          end else begin
            state <= S_EV;
          end
        end
        S_EV: begin
          if (nxt > RW) begin
            status <= fail_status;
            state  <= S_DONE;
          end else begin
            case (op)
              OP_ALLOC: begin
                if (neg && sz >= want) begin
                  tsz     <= sz;
                  split   <= (sz >= want + XW'(2));
                  payload <= i + XW'(1);
                  wcnt    <= 2'd0;
                  state   <= S_WR;
                end else begin
                  i     <= nxt;
                  state <= S_RD;
                end
              end
              OP_STATS: begin
                if (neg) acc_f <= acc_f + sz;
                else acc_u <= acc_u + sz;
                i     <= nxt;
                state <= S_RD;
              end
              OP_FREE: begin
                if (i == hdr) begin
                  if (!neg && mag != '0) begin
                    tsz   <= sz;
                    lo    <= hdr;
                    hi    <= hdr + sz + XW'(1);
                    total <= sz;
                    wcnt  <= 2'd0;
                    state <= (hdr != '0) ? S_PRV_RD : S_NXT_RD;
                  end else begin
                    status <= ST_NULL;
                    state  <= S_DONE;
                  end
                end else if (i > hdr) begin
                  status <= ST_NULL;
                  state  <= S_DONE;
                end else begin
                  i     <= nxt;
                  state <= S_RD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_PRV_RD: state <= S_PRV_EV;
        S_PRV_EV: begin
          // merge with free block below
          if (neg) begin
            lo    <= hdr - sz - XW'(2);
            total <= total + sz + XW'(2);
          end
          state <= S_NXT_RD;
        end
        S_NXT_RD: state <= (hi + XW'(1) < RW) ? S_NXT_EV : S_WR;
        S_NXT_EV: begin
          // merge with free block above
          if (neg) begin
            hi    <= hi + sz + XW'(2);
            total <= total + sz + XW'(2);
          end
          state <= S_WR;
        end
        S_WR: begin
          if (wlast) state <= S_DONE;
          else wcnt <= wcnt + 2'd1;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign used_b = {acc_u, 2'b00};
  assign free_b = {acc_f, 2'b00};

  always_comb begin
    res.status       = status;
    res.payload_word = payload[10:0];
    res.alloc_bytes  = (op == OP_STATS) ? used_b[13:0] : 14'd0;
    res.avail_bytes  = (op == OP_STATS) ? free_b[13:0] : 14'd0;
    res.heap_bytes   = (op == OP_STATS) ? HEAP : 14'd0;
    if (status != ST_OK) begin
      res.alloc_bytes = 14'd0;
      res.avail_bytes = 14'd0;
      res.heap_bytes  = 14'd0;
    end
  end

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_room)
    else $error("result written with no room");
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    res_push |=> state == S_IDLE)
    else $error("sequencer did not return to idle after result");
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_WR || state == S_INIT))
    else $error("tag write outside a write phase");
  a_stats_bound: assert property (@(posedge clk) disable iff (rst)
    (res_push && op == OP_STATS) |-> ((XW+1)'(acc_u) + (XW+1)'(acc_f) <= (XW+1)'(RW)))
    else $error("walk counted more payload than the region holds");
`endif

endmodule

// ===== test/tb_heap_checker.sv =====
// Checker for the boundary-tag heap allocator: watches the command and result
// transfers, keeps its own tag store, predicts each result and compares.
// Depends on bta_pkg.
`timescale 1ns / 1ps
module tb_heap_checker
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [1:0]  process,
  input  logic [15:0] request_bytes,
  input  logic [10:0] block_word,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  status,
  input  logic [10:0] payload_word,
  input  logic [13:0] alloc_bytes,
  input  logic [13:0] avail_bytes,
  input  logic [13:0] heap_bytes,
  output int          errors,
  output int          pending,
  output int          live_cnt [4],
  output logic [10:0] live_word [4][64]
);
  localparam int NPROC = DEF_PROCESSES;
  localparam int RW    = DEF_REGION_WORDS;

  int   tags [NPROC * RW];
  res_t awaited [$];

  function automatic int mag(int t);
    return t < 0 ? -t : t;
  endfunction

  function automatic void reset_heap();
    for (int p = 0; p < NPROC; p++) begin
      tags[p * RW]          = -(RW - 2);
      tags[p * RW + RW - 1] = -(RW - 2);
      live_cnt[p]           = 0;
    end
  endfunction

  // Keep the list of live blocks per region so the stimulus can free real ones.
  function automatic void track(int p, logic [10:0] w, bit add);
    int k;
    if (add) begin
      if (live_cnt[p] < 64) begin
        live_word[p][live_cnt[p]] = w;
        live_cnt[p]++;
      end
    end else begin
      for (k = 0; k < live_cnt[p]; k++)
        if (live_word[p][k] == w) begin
          live_word[p][k] = live_word[p][live_cnt[p] - 1];
          live_cnt[p]--;
          break;
        end
    end
  endfunction

  function automatic res_t predict_heap_op(logic [1:0] op, logic [1:0] pr,
                                           logic [15:0] bytes, logic [10:0] w);
    res_t r;
    int base, want, i, t, s, hdr, lo, hi, total, ps, ns, u, f;
    bit found;
    r = '0;
    base = (pr % NPROC) * RW;
    case (op)
      OP_INIT: begin
        reset_heap();
        r.status = ST_OK;
      end
      OP_ALLOC: begin
        want = (int'(bytes) + 3) >> 2;
        r.status = ST_NOFIT;
        i = 0;
        if (want != 0) begin
          while (i < RW) begin
            t = tags[base + i];
            s = mag(t);
            if (i + s + 2 > RW) break;
            if (t < 0 && s >= want) begin
              if (s >= want + 2) begin
                tags[base + i]            = want;
                tags[base + i + want + 1] = want;
                tags[base + i + want + 2] = -(s - want - 2);
                tags[base + i + s + 1]    = -(s - want - 2);
              end else begin
                tags[base + i]         = s;
                tags[base + i + s + 1] = s;
              end
              r.status = ST_OK;
              r.payload_word = 11'(i + 1);
              track(pr % NPROC, 11'(i + 1), 1);
              break;
            end
            i += s + 2;
          end
        end
      end
      OP_FREE: begin
        r.status = ST_NULL;
        if (w != 0) begin
          hdr = int'(w) - 1;
          i = 0;
          found = 0;
          while (i < RW) begin
            t = tags[base + i];
            s = mag(t);
            if (i + s + 2 > RW) break;
            if (i == hdr) begin
              found = t > 0;
              break;
            end
            if (i > hdr) break;
            i += s + 2;
          end
          if (found) begin
            s = tags[base + hdr];
            lo = hdr;
            hi = hdr + s + 1;
            total = s;
            if (hdr > 0 && tags[base + hdr - 1] < 0) begin
              ps = -tags[base + hdr - 1];
              lo = hdr - ps - 2;
              total += ps + 2;
            end
            if (hi + 1 < RW && tags[base + hi + 1] < 0) begin
              ns = -tags[base + hi + 1];
              hi = hi + ns + 2;
              total += ns + 2;
            end
            tags[base + lo] = -total;
            tags[base + hi] = -total;
            r.status = ST_OK;
            track(pr % NPROC, w, 0);
          end
        end
      end
      default: begin
        u = 0;
        f = 0;
        i = 0;
        while (i < RW) begin
          t = tags[base + i];
          s = mag(t);
          if (i + s + 2 > RW) break;
          if (t < 0) f += s * 4;
          else u += s * 4;
          i += s + 2;
        end
        r.status = ST_OK;
        r.alloc_bytes = 14'(u);
        r.avail_bytes = 14'(f);
        r.heap_bytes = 14'(RW * 4);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want_r;
    res_t got;
    if (rst) begin
      reset_heap();
      awaited.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (!empty && pop) begin
        got = '{status, payload_word, alloc_bytes, avail_bytes, heap_bytes};
        if (awaited.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer %p", got);
          errors <= errors + 1;
        end else begin
          want_r = awaited.pop_front();
          if (got != want_r) begin
            if (errors < 10) $display("mismatch: expected %p got %p", want_r, got);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full)
        awaited.push_back(predict_heap_op(opcode, process, request_bytes, block_word));
      pending <= awaited.size();
    end
  end
endmodule

// ===== test/tb_top.sv =====
// Top of the heap allocator testbench: clock, reset, stimulus and verdict.
// Depends on bta_pkg, boundary_tag_heap_allocator and tb_heap_checker.
`timescale 1ns / 1ps
module tb_top;
  import bta_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic [1:0]  opcode = OP_STATS;
  logic [1:0]  process = 0;
  logic [15:0] request_bytes = 0;
  logic [10:0] block_word = 0;
  logic        pop = 0;
  logic        full, empty;
  logic [1:0]  status;
  logic [10:0] payload_word;
  logic [13:0] alloc_bytes, avail_bytes, heap_bytes;
  int          errors, pending;
  int          live_cnt [4];
  logic [10:0] live_word [4][64];
  int          sender_idle, receiver_stall;
  int          sent, cycles;
  int          op_seen [4];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  boundary_tag_heap_allocator dut (.*);

  tb_heap_checker chk (.*);

  // Random receiver stalls.
  always @(posedge clk)
    pop <= ($urandom_range(99) >= receiver_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("boundary_tag_heap_allocator test failed");
      $finish;
    end
  end

  // Hold each command until its transfer, with random gaps before it.
  task automatic issue_cmd(logic [1:0] op, logic [1:0] pr, logic [15:0] b,
                           logic [10:0] w);
    if ($urandom_range(99) < sender_idle) begin
      push <= 0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle) @(posedge clk);
    end
    push <= 1;
    opcode <= op;
    process <= pr;
    request_bytes <= b;
    block_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    op_seen[op]++;
    sent++;
  endtask

  // Drop push and wait until every expected result has come back.
  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_cmd();
    int r;
    logic [1:0] pr;
    pr = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 1)
      issue_cmd(OP_INIT, pr, 16'($urandom), 11'($urandom));
    else if (r < 45) begin
      // mostly small sizes, a few huge ones
      if ($urandom_range(19) == 0) issue_cmd(OP_ALLOC, pr, 16'($urandom), 11'($urandom));
      else issue_cmd(OP_ALLOC, pr, 16'($urandom_range(200)), 11'($urandom));
    end else if (r < 80 && live_cnt[pr] > 0)
      issue_cmd(OP_FREE, pr, 16'($urandom),
                live_word[pr][$urandom_range(live_cnt[pr] - 1)]);
    else if (r < 88)
      issue_cmd(OP_FREE, pr, 16'($urandom), 11'($urandom));
    else
      issue_cmd(OP_STATS, pr, 16'($urandom), 11'($urandom));
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    sender_idle = 0;
    receiver_stall = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, every operation, the special cases.
    issue_cmd(OP_STATS, 2'd3, 16'hFFFF, 11'h7FF);
    issue_cmd(OP_ALLOC, 2'd0, 16'd0, 11'd0);
    issue_cmd(OP_ALLOC, 2'd0, 16'hFFFF, 11'd0);
    issue_cmd(OP_ALLOC, 2'd0, 16'd1, 11'd0);
    issue_cmd(OP_ALLOC, 2'd0, 16'd5, 11'd0);
    issue_cmd(OP_FREE, 2'd0, 16'd0, 11'd0);
    issue_cmd(OP_FREE, 2'd0, 16'd0, 11'd1);
    issue_cmd(OP_FREE, 2'd0, 16'd0, 11'd1);
    issue_cmd(OP_FREE, 2'd0, 16'd0, 11'h7FF);
    issue_cmd(OP_ALLOC, 2'd1, 16'd8184, 11'd0);
    issue_cmd(OP_ALLOC, 2'd1, 16'd1, 11'd0);
    issue_cmd(OP_STATS, 2'd1, 16'd0, 11'd0);
    issue_cmd(OP_FREE, 2'd1, 16'd0, 11'd1);
    issue_cmd(OP_ALLOC, 2'd2, 16'd8176, 11'd0);
    issue_cmd(OP_ALLOC, 2'd2, 16'd1, 11'd0);
    issue_cmd(OP_STATS, 2'd2, 16'd0, 11'd0);
    issue_cmd(OP_ALLOC, 2'd3, 16'd8180, 11'd0);
    issue_cmd(OP_STATS, 2'd3, 16'd0, 11'd0);
    issue_cmd(OP_INIT, 2'd0, 16'd0, 11'd0);
    issue_cmd(OP_STATS, 2'd2, 16'd0, 11'd0);
    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle    = (ph == 1) ? 47 : (ph == 3) ? 19 : 0;
      receiver_stall = (ph == 2) ? 47 : (ph == 3) ? 19 : 0;
      for (int n = 0; n < 410; n++) random_cmd();
      // drain fully once mid-run
      if (ph == 1) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d commands: %0d init, %0d alloc, %0d free, %0d stats, over four idle mixes.",
             sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    if (errors == 0) $display("boundary_tag_heap_allocator test passed");
    else $display("boundary_tag_heap_allocator test failed");
    $finish;
  end
endmodule
